FILE: rtl/palette_threshold_mono_framebuffer_core_assert.svh
// ----------------------------------------------------------------------------
// palette_threshold_mono_framebuffer_core_assert
// Assertion macros shared by the framebuffer core modules.
// ----------------------------------------------------------------------------
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef PALETTE_THRESHOLD_MONO_FRAMEBUFFER_CORE_ASSERT_SVH
`define PALETTE_THRESHOLD_MONO_FRAMEBUFFER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTMF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ptmf: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PTMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ptmf: next-cycle check failed");

`endif

FILE: rtl/ptmf_pkg.sv
// ----------------------------------------------------------------------------
// ptmf_pkg
// Types, codes and helper functions for the mono framebuffer core.
// ----------------------------------------------------------------------------
package ptmf_pkg;

    // item operations
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_FRAME = 2'd3;

    // transmit byte kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;
    localparam logic [1:0] KIND_ZERO  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_TRANSPARENT = 2'd0;
    localparam logic [1:0] REG_BACKGROUND  = 2'd1;
    localparam logic [1:0] REG_TRANSP_ON   = 2'd2;
    localparam logic [1:0] REG_RESTORE     = 2'd3;

    typedef struct packed {
        logic [7:0] transparent_index;
        logic [7:0] background_index;
        logic       transparency_on;
        logic       restore_background;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  index_value;
        logic [15:0] color565;
        logic [8:0]  column;
        logic [7:0]  row;
        logic [13:0] read_address;
    } item_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic div;
        logic rem;
        logic fix;
        logic addr;
        logic fetch;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic       clear_done;
        logic       out_free;
    } sts_t;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    // red + 2*green + blue on a common scale, threshold at 512
    function automatic logic luma_bit(input logic [15:0] c);
        logic [9:0] sum;
        sum = {2'b00, c[15:11], 3'b000} + {1'b0, c[10:5], 3'b000}
            + {2'b00, c[4:0], 3'b000};
        return sum[9];
    endfunction

endpackage

FILE: rtl/ptmf_cfg.sv
// ----------------------------------------------------------------------------
// ptmf_cfg
// APB register file holding the transparency and background settings.
// ----------------------------------------------------------------------------
module ptmf_cfg
    import ptmf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_TRANSPARENT: cfg_reg.transparent_index  <= pwdata[7:0];
                REG_BACKGROUND:  cfg_reg.background_index   <= pwdata[7:0];
                REG_TRANSP_ON:   cfg_reg.transparency_on    <= pwdata[0];
                REG_RESTORE:     cfg_reg.restore_background <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_TRANSPARENT: prdata = {24'd0, cfg_reg.transparent_index};
            REG_BACKGROUND:  prdata = {24'd0, cfg_reg.background_index};
            REG_TRANSP_ON:   prdata = {31'd0, cfg_reg.transparency_on};
            REG_RESTORE:     prdata = {31'd0, cfg_reg.restore_background};
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/ptmf_ctrl.sv
// ----------------------------------------------------------------------------
// ptmf_ctrl
// Sequencer: clearing pass, then one item at a time through the datapath.
// ----------------------------------------------------------------------------
`include "palette_threshold_mono_framebuffer_core_assert.svh"

module ptmf_ctrl
    import ptmf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_op,
    output logic       s_tready,
    input  sts_t       sts,
    output cmd_t       cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_REM   = 3'd3;
    localparam logic [2:0] ST_FIX   = 3'd4;
    localparam logic [2:0] ST_ADDR  = 3'd5;
    localparam logic [2:0] ST_FETCH = 3'd6;
    localparam logic [2:0] ST_EXEC  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    case (s_op)
                        OP_DRAW: state_next = ST_ADDR;
                        OP_READ: state_next = ST_DIV;
                        default: state_next = ST_EXEC;
                    endcase
                end
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = ST_REM;
            end
            ST_REM: begin
                cmd.rem    = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                // hold until the output register can take the result
                if (sts.out_free) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    `PTMF_ASSERT_NEXT(a_accept_goes_busy, aclk, aresetn, accept, state_reg != ST_IDLE)
    `PTMF_ASSERT_IMP(a_capture_in_idle, aclk, aresetn, cmd.capture, state_reg == ST_IDLE)
    `PTMF_ASSERT_IMP(a_exec_out_free, aclk, aresetn, cmd.exec, sts.out_free)

endmodule

FILE: rtl/ptmf_dp.sv
// ----------------------------------------------------------------------------
// ptmf_dp
// Palette, framebuffer memory, transmit address decode and result register.
// ----------------------------------------------------------------------------
`include "palette_threshold_mono_framebuffer_core_assert.svh"

module ptmf_dp
    import ptmf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 400,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  item_t      item,
    input  cmd_t       cmd,
    output sts_t       sts,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] read_data,
    output logic       pixel_written
);

    localparam int ROWBYTES   = (SCREEN_WIDTH + 7) / 8;
    localparam int PITCH      = ROWBYTES + 2;
    localparam int FRAME_SIZE = ROWBYTES * SCREEN_HEIGHT;
    localparam int LINES_END  = 1 + SCREEN_HEIGHT * PITCH;
    localparam int CLR_LEN    = (FRAME_SIZE > 256) ? FRAME_SIZE : 256;
    localparam int CLR_W      = $clog2(CLR_LEN);
    localparam int FB_AW      = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
    localparam int RECIP      = (1 << 16) / PITCH;

    // captured item
    logic [1:0]  op_reg;
    logic [7:0]  idx_reg;
    logic [15:0] color_reg;
    logic [8:0]  col_reg;
    logic [7:0]  row_reg;
    logic [13:0] addr_reg;

    // transmit address decode
    logic [13:0] k_val;
    logic [29:0] prod_reg;
    logic [13:0] est_reg;
    logic [7:0]  rem_reg;
    logic [7:0]  line_reg;
    logic [7:0]  pos_reg;
    logic [1:0]  kind_reg;
    logic [13:0] est_val;
    logic [13:0] rem_val;
    logic [13:0] line_val;
    logic [7:0]  pos_val;
    logic [1:0]  kind_val;

    // draw path
    logic        match;
    logic [7:0]  eff_idx;
    logic        draw_ok_val;
    logic        draw_ok_reg;
    logic [2:0]  bit_reg;
    logic [7:0]  mul_a;
    logic [7:0]  mul_off;
    logic [15:0] lin_addr;
    logic [FB_AW-1:0] fb_addr_reg;

    // memories
    logic [7:0]  fb_mem_reg [FRAME_SIZE];
    logic        pal_mem_reg [256];
    logic [7:0]  rd_byte_reg;
    logic        pal_bit_reg;
    logic        fb_we;
    logic [FB_AW-1:0] fb_waddr;
    logic [7:0]  fb_wdata;
    logic [7:0]  mask;
    logic        pal_we;
    logic [7:0]  pal_waddr;
    logic        pal_wdata;

    logic [CLR_W-1:0] clr_cnt_reg;
    logic        vcom_reg;
    logic        out_valid_reg;
    logic [7:0]  rdata_reg;
    logic        written_reg;
    logic [7:0]  rdata_val;

    // capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= item.operation;
            idx_reg   <= item.index_value;
            color_reg <= item.color565;
            col_reg   <= item.column;
            row_reg   <= item.row;
            addr_reg  <= item.read_address;
        end
    end

    // line = k / PITCH by reciprocal; estimate is exact or one short
    assign k_val   = addr_reg - 14'd1;
    assign est_val = prod_reg[29:16];
    assign rem_val = k_val - 14'(est_val * 14'(PITCH));

    always_comb begin
        if (rem_reg >= 8'(PITCH)) begin
            line_val = est_reg + 14'd1;
            pos_val  = rem_reg - 8'(PITCH);
        end else begin
            line_val = est_reg;
            pos_val  = rem_reg;
        end
        if (addr_reg == 14'd0) begin
            kind_val = KIND_START;
        end else if ({1'b0, addr_reg} >= 15'(LINES_END)) begin
            kind_val = KIND_ZERO;
        end else if (pos_val == 8'd0) begin
            kind_val = KIND_LINE;
        end else if (pos_val == 8'(PITCH - 1)) begin
            kind_val = KIND_ZERO;
        end else begin
            kind_val = KIND_PIXEL;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div) begin
            prod_reg <= 30'(k_val) * 30'(RECIP);
        end
        if (cmd.rem) begin
            est_reg <= est_val;
            rem_reg <= rem_val[7:0];
        end
        if (cmd.fix) begin
            line_reg <= line_val[7:0];
            pos_reg  <= pos_val;
            kind_reg <= kind_val;
        end
    end

    // draw decision and byte address, shared multiplier for both paths
    assign match   = (idx_reg == cfg.transparent_index);
    assign eff_idx = (cfg.restore_background && match) ? cfg.background_index : idx_reg;
    assign draw_ok_val = !(!cfg.restore_background && cfg.transparency_on && match)
                         && ({23'd0, col_reg} < 32'(SCREEN_WIDTH))
                         && ({24'd0, row_reg} < 32'(SCREEN_HEIGHT));
    assign mul_a    = (op_reg == OP_DRAW) ? row_reg : line_reg;
    assign mul_off  = (op_reg == OP_DRAW) ? {2'b00, col_reg[8:3]} : (pos_reg - 8'd1);
    assign lin_addr = 16'(mul_a) * 16'(ROWBYTES) + 16'(mul_off);

    always_ff @(posedge aclk) begin
        if (cmd.addr) begin
            fb_addr_reg <= lin_addr[FB_AW-1:0];
            draw_ok_reg <= draw_ok_val;
            bit_reg     <= col_reg[2:0];
        end
    end

    // clearing sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear && !sts.clear_done) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign mask = 8'h80 >> bit_reg;

    always_comb begin
        fb_we    = 1'b0;
        fb_waddr = fb_addr_reg;
        fb_wdata = pal_bit_reg ? (rd_byte_reg | mask) : (rd_byte_reg & ~mask);
        if (cmd.clear) begin
            fb_we    = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(FRAME_SIZE));
            fb_waddr = clr_cnt_reg[FB_AW-1:0];
            fb_wdata = 8'd0;
        end else if (cmd.exec && op_reg == OP_DRAW && draw_ok_reg) begin
            fb_we = 1'b1;
        end
    end

    always_comb begin
        pal_we    = 1'b0;
        pal_waddr = idx_reg;
        pal_wdata = luma_bit(color_reg);
        if (cmd.clear) begin
            pal_we    = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(256));
            pal_waddr = clr_cnt_reg[7:0];
            pal_wdata = 1'b0;
        end else if (cmd.exec && op_reg == OP_LOAD) begin
            pal_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fb_we) begin
            fb_mem_reg[fb_waddr] <= fb_wdata;
        end
        if (cmd.fetch) begin
            rd_byte_reg <= fb_mem_reg[fb_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem_reg[pal_waddr] <= pal_wdata;
        end
        if (cmd.addr) begin
            pal_bit_reg <= pal_mem_reg[eff_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcom_reg <= 1'b0;
        end else if (cmd.exec && op_reg == OP_FRAME) begin
            vcom_reg <= ~vcom_reg;
        end
    end

    // result byte
    always_comb begin
        rdata_val = 8'd0;
        if (op_reg == OP_READ) begin
            case (kind_reg)
                KIND_START: rdata_val = {1'b1, vcom_reg, 6'd0};
                KIND_LINE:  rdata_val = reverse8(line_reg + 8'd1);
                KIND_PIXEL: rdata_val = rd_byte_reg;
                KIND_ZERO:  rdata_val = 8'd0;
                default:    rdata_val = 8'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            rdata_reg   <= rdata_val;
            written_reg <= (op_reg == OP_DRAW) && draw_ok_reg;
        end
    end

    assign sts.clear_done = (clr_cnt_reg == CLR_W'(CLR_LEN - 1));
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid      = out_valid_reg;
    assign read_data     = rdata_reg;
    assign pixel_written = written_reg;

    `PTMF_ASSERT_IMP(a_capture_after_clear, aclk, aresetn, cmd.capture, sts.clear_done)
    `PTMF_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.exec, !out_valid_reg || m_tready)
    `PTMF_ASSERT_IMP(a_valid_from_exec, aclk, aresetn, $rose(out_valid_reg), $past(cmd.exec))

endmodule

FILE: rtl/palette_threshold_mono_framebuffer_core.sv
// ----------------------------------------------------------------------------
// palette_threshold_mono_framebuffer_core
// Palette-indexed pixel renderer into a 1-bpp memory LCD framebuffer.
// ----------------------------------------------------------------------------
//  channel  | ports                      | moves
//  ---------+----------------------------+-------------------------------------
//  s_       | s_tvalid s_tready s_tdata  | one item: load, draw, read or frame
//           | s_tuser                    |
//  m_       | m_tvalid m_tready m_tdata  | one result item per input item
//  apb      | psel penable pwrite paddr  | configuration registers
//           | pwdata prdata pready       |
//
//  Items run one at a time through a shared sequencer. Load palette and
//  frame done go from acceptance straight to the execute step; draw pixel
//  first takes the address and fetch steps, read byte also the divide,
//  remainder and fix steps. The read path is set by the reciprocal multiply
//  for the line number, its correction and the registered framebuffer read;
//  the draw path by the palette read and the framebuffer read-modify-write.
//  After reset a clearing pass writes zero to every address of the
//  framebuffer and palette; no item is accepted meanwhile, configuration
//  writes are.
//  A result waits in the output register while the next item is taken; a
//  stalled m_ side holds the sequencer in its last step, taking no new item.
// ----------------------------------------------------------------------------
module palette_threshold_mono_framebuffer_core
    import ptmf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 400,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] index_value, [23:8] color565, [32:24] column, [40:33] row,
    // [54:41] read_address, [55] zero
    input  logic [55:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] pixel_written, [15:9] zero
    output logic [15:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg;
    item_t      item;
    cmd_t       cmd;
    sts_t       sts;
    logic [7:0] read_data;
    logic       pixel_written;

    // unpack the item fields from the stream
    assign item.operation    = s_tuser;
    assign item.index_value  = s_tdata[7:0];
    assign item.color565     = s_tdata[23:8];
    assign item.column       = s_tdata[32:24];
    assign item.row          = s_tdata[40:33];
    assign item.read_address = s_tdata[54:41];

    ptmf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptmf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ptmf_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .item          (item),
        .cmd           (cmd),
        .sts           (sts),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .read_data     (read_data),
        .pixel_written (pixel_written)
    );

    // pack the result, pad to whole bytes
    assign m_tdata = {7'd0, pixel_written, read_data};

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the palette-threshold mono framebuffer core.
// A short table of hand-picked items comes first: image edges, palette
// threshold, off-screen draws, transparency and VCOM toggling. Random phases
// follow, each under its own register setting. Every accepted item is run
// through a local model of the palette, framebuffer and VCOM state, and every
// result item is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import ptmf_pkg::*;

    // display geometry, as built into the core by default
    localparam int SCR_W     = 400;
    localparam int SCR_H     = 240;
    localparam int ROW_BYTES = (SCR_W + 7) / 8;
    localparam int PITCH     = ROW_BYTES + 2;
    // first address past the last line of the transmit image
    localparam int IMG_END   = 1 + SCR_H * PITCH;

    // allow well beyond the clearing pass after reset
    localparam int QUIET_LIMIT = 40000;
    // long receiver hold-off, enough to back the core up into its input
    localparam int HOLD_CYCLES = 600;
    localparam int HOLD_AFTER  = 400;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int NUM_PHASES      = 6;

    typedef struct packed {
        logic [7:0] read_data;
        logic       pixel_written;
    } px_result_t;

    // hand-typed expectation for a directed row, if it has one
    typedef struct {
        bit         typed;
        px_result_t res;
    } fixed_t;

    typedef struct {
        bit         is_cfg;
        logic [1:0] reg_sel;
        logic [7:0] reg_val;
        item_t      it;
        bit         typed;
        px_result_t res;
    } step_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [7:0] index_value, [23:8] color565, [32:24] column, [40:33] row,
    // [54:41] read_address, [55] zero
    logic [55:0] s_tdata  = '0;
    // [1:0] operation
    logic [1:0]  s_tuser  = OP_LOAD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] read_data, [8] pixel_written, [15:9] zero
    logic [15:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    palette_threshold_mono_framebuffer_core #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Local copy of the core's state: palette bits, framebuffer, VCOM and
    // the register file. Registers only change while the core is idle.
    // ------------------------------------------------------------------
    logic       shadow_palette [256];
    logic [7:0] shadow_frame   [ROW_BYTES*SCR_H];
    logic       shadow_vcom;
    cfg_t       shadow_cfg;

    px_result_t pending_results [$];
    fixed_t     fixed_results   [$];
    step_t      steps           [$];

    int mismatches   = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int burst_left   = 0;

    logic [8:0] last_column = '0;
    logic [7:0] last_row    = '0;

    // r + g + b on the 5/6/5 scale reaches 64 exactly when the weighted
    // sum crosses 512
    function automatic logic luma_is_light(input logic [15:0] c);
        int s;
        s = int'(c[15:11]) + int'(c[10:5]) + int'(c[4:0]);
        return s >= 64;
    endfunction

    function automatic logic [7:0] flip_bits(input logic [7:0] v);
        logic [7:0] r;
        r = {<<{v}};
        return r;
    endfunction

    // one byte of the transmit image as the panel would receive it
    function automatic logic [7:0] tx_byte(input int a);
        int k;
        int line;
        int pos;
        if (a == 0)
            return {1'b1, shadow_vcom, 6'b000000};
        if (a >= IMG_END)
            return 8'h00;
        k    = a - 1;
        line = k / PITCH;
        pos  = k % PITCH;
        if (pos == 0)
            return flip_bits(8'(line + 1));
        if (pos == PITCH - 1)
            return 8'h00;
        return shadow_frame[line*ROW_BYTES + pos - 1];
    endfunction

    // apply one item to the local state and return the result it causes
    function automatic px_result_t render_item(input item_t it);
        px_result_t res;
        logic [7:0] pal_idx;
        logic [7:0] mask;
        logic       paint;
        int         byte_at;
        res = '0;
        case (it.operation)
            OP_LOAD: begin
                shadow_palette[it.index_value] = luma_is_light(it.color565);
            end
            OP_DRAW: begin
                pal_idx = it.index_value;
                paint   = 1'b1;
                // restore wins over skipping
                if (shadow_cfg.restore_background) begin
                    if (pal_idx == shadow_cfg.transparent_index)
                        pal_idx = shadow_cfg.background_index;
                end else if (shadow_cfg.transparency_on
                             && pal_idx == shadow_cfg.transparent_index) begin
                    paint = 1'b0;
                end
                if (paint && it.column < SCR_W && it.row < SCR_H) begin
                    byte_at = int'(it.row) * ROW_BYTES + int'(it.column[8:3]);
                    mask    = 8'h80 >> it.column[2:0];
                    if (shadow_palette[pal_idx])
                        shadow_frame[byte_at] = shadow_frame[byte_at] | mask;
                    else
                        shadow_frame[byte_at] = shadow_frame[byte_at] & ~mask;
                    res.pixel_written = 1'b1;
                end
            end
            OP_READ: begin
                res.read_data = tx_byte(int'(it.read_address));
            end
            default: begin
                shadow_vcom = ~shadow_vcom;
            end
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: predict on acceptance of an input item, then compare on
    // acceptance of a result item. Prediction goes first so that a result
    // landing on the same edge would still find its expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        item_t      it;
        px_result_t want;
        fixed_t     fx;
        if (aresetn && s_tvalid && s_tready) begin
            it   = {s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[32:24],
                    s_tdata[40:33], s_tdata[54:41]};
            want = render_item(it);
            fx   = fixed_results.pop_front();
            if (fx.typed)
                want = fx.res;
            pending_results.push_back(want);
        end
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result item %04h with nothing expected", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[7:0] !== want.read_data)
                    flag_mismatch($sformatf("read_data expected %02h, got %02h",
                                            want.read_data, m_tdata[7:0]));
                if (m_tdata[8] !== want.pixel_written)
                    flag_mismatch($sformatf("pixel_written expected %0b, got %0b",
                                            want.pixel_written, m_tdata[8]));
            end
        end
    end

    // watchdog: end the run if nothing moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random ready pattern, mostly short stalls with a few
    // long ones, plus one long hold-off that backs the core up.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int  run;
        int  pick;
        bit  held;
        held = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    m_tready <= 1'b1;
                    run = $urandom_range(1, 40);
                end else begin
                    m_tready <= 1'b0;
                    if (pick < 85)
                        run = $urandom_range(1, 3);
                    else if (pick < 97)
                        run = $urandom_range(4, 12);
                    else
                        run = $urandom_range(20, 60);
                end
                repeat (run) @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one item and hold it until the core takes it, then idle a while if a gap is picked
    task automatic offer_item(input item_t it, input bit typed, input px_result_t res);
        fixed_t fx;
        int     gap;
        fx.typed = typed;
        fx.res   = res;
        fixed_results.push_back(fx);
        s_tuser  <= it.operation;
        s_tdata  <= {1'b0, it.read_address, it.row, it.column, it.color565,
                     it.index_value};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        // the core is idle once its last result has gone
        repeat (3) @(posedge aclk);
    endtask

    // setup cycle, access cycle, then release the bus
    task automatic reg_write(input logic [1:0] sel, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {24'h000000, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_TRANSPARENT: shadow_cfg.transparent_index  = val;
            REG_BACKGROUND:  shadow_cfg.background_index   = val;
            REG_TRANSP_ON:   shadow_cfg.transparency_on    = val[0];
            default:         shadow_cfg.restore_background = val[0];
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [7:0] transp, input logic [7:0] backgr,
                                 input logic on, input logic restore);
        wait_drain();
        reg_write(REG_TRANSPARENT, transp);
        reg_write(REG_BACKGROUND, backgr);
        reg_write(REG_TRANSP_ON, {7'd0, on});
        reg_write(REG_RESTORE, {7'd0, restore});
    endtask

    function automatic void add_item(input logic [1:0] op, input logic [7:0] idx,
                                     input logic [15:0] color, input logic [8:0] col,
                                     input logic [7:0] row, input logic [13:0] addr,
                                     input bit typed, input logic [7:0] rd,
                                     input logic wr);
        step_t s;
        s.is_cfg  = 1'b0;
        s.reg_sel = REG_TRANSPARENT;
        s.reg_val = 8'h00;
        s.it      = {op, idx, color, col, row, addr};
        s.typed   = typed;
        s.res     = {rd, wr};
        steps.push_back(s);
    endfunction

    function automatic void add_cfg(input logic [1:0] sel, input logic [7:0] val);
        step_t s;
        s.is_cfg  = 1'b1;
        s.reg_sel = sel;
        s.reg_val = val;
        s.it      = '0;
        s.typed   = 1'b0;
        s.res     = '0;
        steps.push_back(s);
    endfunction

    // random item shaped to hit neighbouring pixels, transparent indexes
    // and the edges of the transmit image
    function automatic item_t make_random_item();
        item_t it;
        int    pick;
        int    line;
        it.operation    = OP_FRAME;
        it.index_value  = 8'($urandom);
        it.color565     = 16'($urandom);
        it.column       = 9'($urandom);
        it.row          = 8'($urandom);
        it.read_address = 14'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            it.operation = OP_DRAW;
            pick = $urandom_range(0, 99);
            if (pick < 25)
                it.index_value = shadow_cfg.transparent_index;
            else if (pick < 35)
                it.index_value = shadow_cfg.background_index;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // same byte as the last draw: back-to-back read-modify-write
                it.column = {last_column[8:3], 3'($urandom)};
                it.row    = last_row;
            end else if (pick < 85) begin
                it.column = 9'($urandom_range(0, SCR_W - 1));
                it.row    = 8'($urandom_range(0, SCR_H - 1));
            end
            last_column = it.column;
            last_row    = it.row;
        end else if (pick < 65) begin
            it.operation = OP_LOAD;
            pick = $urandom_range(0, 99);
            if (pick < 15)
                it.index_value = shadow_cfg.transparent_index;
            else if (pick < 30)
                it.index_value = shadow_cfg.background_index;
        end else if (pick < 93) begin
            it.operation = OP_READ;
            line = $urandom_range(0, SCR_H - 1);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                it.read_address = 14'(2 + int'(last_row) * PITCH + int'(last_column[8:3]));
            else if (pick < 50)
                it.read_address = '0;
            else if (pick < 60)
                it.read_address = 14'(1 + line * PITCH);
            else if (pick < 70)
                it.read_address = 14'((line + 1) * PITCH);
            else if (pick < 80)
                it.read_address = 14'($urandom_range(IMG_END - PITCH, IMG_END + 4));
            else if (pick < 90)
                it.read_address = 14'($urandom_range(0, IMG_END));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        step_t s;
        item_t it;
        foreach (shadow_palette[i]) shadow_palette[i] = 1'b0;
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
        shadow_vcom = 1'b0;
        shadow_cfg  = '0;

        // directed rows: typed results only where they are obvious
        // image edges on a cleared screen
        add_item(OP_READ, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd0, 1, 8'h80, 1'b0);
        add_item(OP_READ, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd1, 1, 8'h80, 1'b0);
        add_item(OP_READ, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd2, 1, 8'h00, 1'b0);
        add_item(OP_READ, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd52, 1, 8'h00, 1'b0);
        add_item(OP_READ, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd12429, 1, 8'h0f, 1'b0);
        // final terminating byte and beyond
        add_item(OP_READ, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd12481, 1, 8'h00, 1'b0);
        add_item(OP_READ, 8'hff, 16'hffff, 9'h1ff, 8'hff, 14'h3fff, 1, 8'h00, 1'b0);
        // VCOM toggle shows in the start byte
        add_item(OP_FRAME, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd0, 1, 8'h00, 1'b0);
        add_item(OP_READ, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd0, 1, 8'hc0, 1'b0);
        // palette: white, just on the threshold, just under it
        add_item(OP_LOAD, 8'd255, 16'hffff, 9'd0, 8'd0, 14'd0, 1, 8'h00, 1'b0);
        add_item(OP_LOAD, 8'd1, 16'hfc20, 9'd0, 8'd0, 14'd0, 1, 8'h00, 1'b0);
        add_item(OP_LOAD, 8'd2, 16'hfc00, 9'd0, 8'd0, 14'd0, 1, 8'h00, 1'b0);
        // corner pixels, then read them back
        add_item(OP_DRAW, 8'd255, 16'h0000, 9'd0, 8'd0, 14'd0, 1, 8'h00, 1'b1);
        add_item(OP_READ, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd2, 1, 8'h80, 1'b0);
        add_item(OP_DRAW, 8'd255, 16'h0000, 9'd399, 8'd239, 14'd0, 1, 8'h00, 1'b1);
        add_item(OP_READ, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd12479, 1, 8'h01, 1'b0);
        add_item(OP_DRAW, 8'd1, 16'h0000, 9'd1, 8'd0, 14'd0, 0, 8'h00, 1'b0);
        add_item(OP_DRAW, 8'd2, 16'h0000, 9'd0, 8'd0, 14'd0, 0, 8'h00, 1'b0);
        add_item(OP_READ, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd2, 0, 8'h00, 1'b0);
        // off-screen draws are dropped
        add_item(OP_DRAW, 8'd255, 16'h0000, 9'd400, 8'd0, 14'd0, 1, 8'h00, 1'b0);
        add_item(OP_DRAW, 8'd255, 16'hffff, 9'd511, 8'd255, 14'd0, 1, 8'h00, 1'b0);
        add_item(OP_DRAW, 8'd255, 16'h0000, 9'd0, 8'd240, 14'd0, 1, 8'h00, 1'b0);
        // transparent pixel skipped
        add_cfg(REG_TRANSPARENT, 8'd9);
        add_cfg(REG_TRANSP_ON, 8'd1);
        add_item(OP_DRAW, 8'd9, 16'h0000, 9'd8, 8'd1, 14'd0, 1, 8'h00, 1'b0);
        // restore replaces the transparent index by the background index
        add_cfg(REG_BACKGROUND, 8'd255);
        add_cfg(REG_RESTORE, 8'd1);
        add_item(OP_DRAW, 8'd9, 16'h0000, 9'd8, 8'd1, 14'd0, 1, 8'h00, 1'b1);
        add_item(OP_READ, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd55, 0, 8'h00, 1'b0);
        add_item(OP_FRAME, 8'd0, 16'h0000, 9'd0, 8'd0, 14'd0, 1, 8'h00, 1'b0);

        // hold reset, once
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        burst_left = 10;
        foreach (steps[i]) begin
            s = steps[i];
            if (s.is_cfg) begin
                wait_drain();
                reg_write(s.reg_sel, s.reg_val);
            end else begin
                offer_item(s.it, s.typed, s.res);
            end
        end

        // random phases, one register setting each, extremes included
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: apply_setting(8'd0, 8'd0, 1'b0, 1'b0);
                1: apply_setting(8'd255, 8'd0, 1'b1, 1'b0);
                2: apply_setting(8'd0, 8'd255, 1'b0, 1'b1);
                3: apply_setting(8'($urandom), 8'($urandom), 1'b1, 1'b1);
                4: apply_setting(8'($urandom), 8'($urandom), 1'b1, 1'b0);
                default: apply_setting(8'd17, 8'd200, 1'b0, 1'b0);
            endcase
            // open each phase with a stretch at full rate
            burst_left = 40;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // now and then pause until the core has emptied
                if (n > 0 && n % 70 == 0)
                    wait_drain();
                it = make_random_item();
                offer_item(it, 1'b0, '0);
            end
        end

        wait_drain();
        repeat (20) @(posedge aclk);

        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
